FILE: rtl/dtb_pkg.sv
// ----------------------------------------------------------------------------
// dtb_pkg: shared types and constants of the duotone tint blend unit
// Register map codes, fixed-point constants and the divide-by-255 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dtb_pkg;

  // register index on the configuration port (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_DARK_RED     = 3'd0,
    REG_DARK_GREEN   = 3'd1,
    REG_DARK_BLUE    = 3'd2,
    REG_LIGHT_RED    = 3'd3,
    REG_LIGHT_GREEN  = 3'd4,
    REG_LIGHT_BLUE   = 3'd5,
    REG_BLEND_AMOUNT = 3'd6
  } dtb_reg_e;

  // blend amount of 1.0 in Q1.16
  localparam logic [16:0] AMT_ONE = 17'h10000;

  // luma weights (per mille)
  localparam logic [9:0] LUMA_W_R = 10'd299;
  localparam logic [9:0] LUMA_W_G = 10'd587;
  localparam logic [9:0] LUMA_W_B = 10'd114;

  // floor(x / 1000) = (x * LUMA_MUL) >> 28, exact for x <= 255000
  localparam logic [18:0] LUMA_MUL = 19'd268436;

  // floor(y / 255) = (y * DIV255_MUL) >> 24, exact for y <= 65152
  localparam logic [16:0] DIV255_MUL = 17'd65794;

  // rounding offsets
  localparam logic [15:0] RND_255  = 16'd127;
  localparam logic [24:0] RND_Q16  = 25'd32768;

  // stages of the un-premultiply divider (setup plus four radix-2 pairs)
  localparam int UPM_STG = 5;

  // per-stage load enables for the divider
  typedef struct packed {
    logic [UPM_STG-1:0] ld;
  } dtb_upm_ctl_t;

  // reciprocal multiply, operand never above 65152 here
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [32:0] p;
    p = {17'd0, y} * {16'd0, DIV255_MUL};
    return p[31:24];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtb_unpremul.sv
// ----------------------------------------------------------------------------
// dtb_unpremul: pipelined un-premultiply of one colour channel
// u = min(255, floor(c * 255 / a)) with a restoring divider, two quotient
// bits per stage; saturation is decided up front from c * 255 >= a * 256.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_unpremul
  import dtb_pkg::*;
(
  input  logic         clk,
  input  dtb_upm_ctl_t ctl,
  input  logic [7:0]   a,
  input  logic [7:0]   c,
  output logic [7:0]   u
);

  logic [15:0] rem [UPM_STG];
  logic [7:0]  quo [UPM_STG];
  logic [7:0]  den [UPM_STG];
  logic        sat [UPM_STG];

  // dividend c * 255
  logic [15:0] num;
  assign num = {c, 8'h00} - {8'h00, c};

  // setup stage: dividend, divisor and saturation flag
  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      rem[0] <= num;
      quo[0] <= '0;
      den[0] <= a;
      sat[0] <= (num >= {a, 8'h00});
    end
  end

  // compare-subtract stages, MSB first
  for (genvar j = 1; j < UPM_STG; j++) begin : g_div
    localparam int TOPB = 2 * (UPM_STG - 1) - 1 - 2 * (j - 1);
    logic [15:0] r_nx;
    logic [7:0]  q_nx;
    logic [15:0] d;

    always_comb begin
      r_nx = rem[j-1];
      q_nx = quo[j-1];
      d    = '0;
      for (int k = 0; k < 2; k++) begin
        d = {8'h00, den[j-1]} << (TOPB - k);
        if (r_nx >= d) begin
          r_nx = r_nx - d;
          q_nx[TOPB-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.ld[j]) begin
        rem[j] <= r_nx;
        quo[j] <= q_nx;
        den[j] <= den[j-1];
        sat[j] <= sat[j-1];
      end
    end
  end

  assign u = sat[UPM_STG-1] ? 8'hFF : quo[UPM_STG-1];

endmodule

`default_nettype wire

FILE: rtl/duotone_tint_blend_unit.sv
// ----------------------------------------------------------------------------
// duotone_tint_blend_unit: duotone tint of premultiplied ARGB pixels
// Un-premultiplies, takes luma, picks a tint between dark and light colour,
// blends toward it and re-premultiplies, one pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ stream (tdata = alpha, red, green, blue from the
//   low byte up) and leave on the m_ stream in the same order and packing.
//   Tint colours and blend amount sit in APB registers at byte addresses
//   0x00..0x18; write them only while no pixel is in flight.
//   Each pixel passes through one input stage, five stages of the
//   un-premultiply divider, then luma sum, luma scale, tint mix, tint
//   rounding, blend, alpha multiply and output. Throughput is one pixel
//   per cycle unless stalled; every stage has its own valid bit, so
//   bubbles close up and s_tready stays high while any stage is empty.
//   When the receiver stalls, the output register holds and the pipeline
//   fills behind it; s_tready drops only once all 13 stages are full.
//   Reset empties the pipeline and loads dark = black, light = white,
//   blend amount = 0 (pixels pass through unchanged).
// ----------------------------------------------------------------------------
`default_nettype none

module duotone_tint_blend_unit
  import dtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input pixel stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // src_alpha, src_red, src_green, src_blue
  // output pixel stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // res_alpha, res_red, res_green, res_blue
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NSTG = 13;

  // data that rides along the whole pipe
  typedef struct packed {
    logic [7:0]       a;
    logic [2:0][7:0]  c;     // original premultiplied channels
    logic [16:0]      amt;   // clamped blend amount
    logic             byp;   // pass through unchanged
  } side_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [2:0][7:0] dark;
  logic [2:0][7:0] light;
  logic [16:0]     amount;
  dtb_reg_e        reg_idx;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = dtb_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark   <= '0;
      light  <= {3{8'hFF}};
      amount <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DARK_RED:     dark[0]  <= pwdata[7:0];
        REG_DARK_GREEN:   dark[1]  <= pwdata[7:0];
        REG_DARK_BLUE:    dark[2]  <= pwdata[7:0];
        REG_LIGHT_RED:    light[0] <= pwdata[7:0];
        REG_LIGHT_GREEN:  light[1] <= pwdata[7:0];
        REG_LIGHT_BLUE:   light[2] <= pwdata[7:0];
        REG_BLEND_AMOUNT: amount   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_DARK_RED:     prdata = {24'd0, dark[0]};
      REG_DARK_GREEN:   prdata = {24'd0, dark[1]};
      REG_DARK_BLUE:    prdata = {24'd0, dark[2]};
      REG_LIGHT_RED:    prdata = {24'd0, light[0]};
      REG_LIGHT_GREEN:  prdata = {24'd0, light[1]};
      REG_LIGHT_BLUE:   prdata = {24'd0, light[2]};
      REG_BLEND_AMOUNT: prdata = {15'd0, amount};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage loads when empty or when its successor
  // loads, so bubbles are squeezed out
  // --------------------------------------------------------------------------
  logic [NSTG:1] vld;
  logic [NSTG:1] vin;
  logic [NSTG:1] en;

  assign vin      = {vld[NSTG-1:1], s_tvalid};
  assign en[NSTG] = ~vld[NSTG] | m_tready;
  for (genvar k = 1; k < NSTG; k++) begin : g_en
    assign en[k] = ~vld[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vin[k];
      end
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[NSTG];

  // --------------------------------------------------------------------------
  // side-band pipe
  // --------------------------------------------------------------------------
  side_t side [1:NSTG];
  side_t side_in;
  logic  amt_zero;

  always_comb begin
    side_in.a    = s_tdata[7:0];
    side_in.c[0] = s_tdata[15:8];
    side_in.c[1] = s_tdata[23:16];
    side_in.c[2] = s_tdata[31:24];
    side_in.amt  = (amount > AMT_ONE) ? AMT_ONE : amount;
    amt_zero     = (amount == '0);
    side_in.byp  = (s_tdata[7:0] == 8'h00) | amt_zero;
  end

  always_ff @(posedge clk) begin
    if (en[1]) side[1] <= side_in;
  end

  for (genvar k = 2; k <= NSTG; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // stages 2..6: un-premultiply, one divider per channel
  // --------------------------------------------------------------------------
  dtb_upm_ctl_t    upm_ctl;
  logic [2:0][7:0] upm_u;

  assign upm_ctl.ld = en[UPM_STG+1:2];

  for (genvar ch = 0; ch < 3; ch++) begin : g_upm
    dtb_unpremul u_upm (
      .clk (clk),
      .ctl (upm_ctl),
      .a   (side[1].a),
      .c   (side[1].c[ch]),
      .u   (upm_u[ch])
    );
  end

  // --------------------------------------------------------------------------
  // stage 7: weighted luma sum; un-premultiplied channels start to travel
  // --------------------------------------------------------------------------
  logic [17:0]     luma_sum;
  logic [2:0][7:0] u7, u8, u9, u10;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      u7       <= upm_u;
      luma_sum <= 18'(upm_u[0] * LUMA_W_R) + 18'(upm_u[1] * LUMA_W_G)
                + 18'(upm_u[2] * LUMA_W_B);
    end
  end

  // stage 8: luma = sum / 1000
  logic [36:0] luma_prod;
  logic [7:0]  luma;

  assign luma_prod = {19'd0, luma_sum} * {18'd0, LUMA_MUL};

  always_ff @(posedge clk) begin
    if (en[8]) begin
      u8   <= u7;
      luma <= luma_prod[35:28];
    end
  end

  // stage 9: tint numerator dark * (255 - L) + light * L
  logic [2:0][15:0] tint_num;
  logic [7:0]       luma_inv;

  assign luma_inv = 8'hFF - luma;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      u9 <= u8;
      for (int ch = 0; ch < 3; ch++) begin
        tint_num[ch] <= 16'(dark[ch] * luma_inv) + 16'(light[ch] * luma);
      end
    end
  end

  // stage 10: tint colour, rounded
  logic [2:0][7:0] tint;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      u10 <= u9;
      for (int ch = 0; ch < 3; ch++) begin
        tint[ch] <= div255(tint_num[ch] + RND_255);
      end
    end
  end

  // stage 11: blend u toward tint by amount, Q0.16 rounding
  logic [16:0]      amt_inv;
  logic [2:0][24:0] blend_sum;
  logic [2:0][7:0]  blend;

  assign amt_inv = AMT_ONE - side[10].amt;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      blend_sum[ch] = 25'(u10[ch] * amt_inv) + 25'(tint[ch] * side[10].amt) + RND_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      for (int ch = 0; ch < 3; ch++) begin
        blend[ch] <= blend_sum[ch][23:16];
      end
    end
  end

  // stage 12: re-premultiply numerator b * a + 127
  logic [2:0][15:0] pm_num;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      for (int ch = 0; ch < 3; ch++) begin
        pm_num[ch] <= 16'(blend[ch] * side[11].a) + RND_255;
      end
    end
  end

  // stage 13: output register, bypass for transparent pixels or zero amount
  logic [2:0][7:0] res;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      for (int ch = 0; ch < 3; ch++) begin
        res[ch] <= side[12].byp ? side[12].c[ch] : div255(pm_num[ch]);
      end
    end
  end

  assign m_tdata = {res[2], res[1], res[0], side[NSTG].a};

endmodule

`default_nettype wire

FILE: rtl/dtb_checker.sv
// ----------------------------------------------------------------------------
// dtb_checker: port-level checks of the duotone tint blend unit
// Reset behavior, flow control and register write/readback.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_checker
  import dtb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [4:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);

  // byte address of the blend amount register
  localparam logic [4:0] AMT_ADDR = {REG_BLEND_AMOUNT, 2'b00};

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input is refused only while the output holds a stalled result
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with a free pipeline");

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output changed while stalled");

  // blend amount reads back what was written
  a_amt_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr == AMT_ADDR) ##1 (paddr == AMT_ADDR)
    |-> prdata == {15'd0, $past(pwdata[16:0])})
    else $error("blend amount readback mismatch");

endmodule

bind duotone_tint_blend_unit dtb_checker u_dtb_checker (.*);

`default_nettype wire

FILE: sim/tint_checker.sv
// ----------------------------------------------------------------------------
// tint_checker: scoreboard for the duotone tint blend unit
// Follows register writes on the APB port, predicts the tinted pixel for
// every input transfer and compares each output transfer against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------

module tint_checker
  import dtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input pixel stream
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // src_alpha, src_red, src_green, src_blue
  // output pixel stream
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // res_alpha, res_red, res_green, res_blue
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  // status to the testbench top
  output int unsigned outstanding,
  output int unsigned fail_count
);

  localparam logic [16:0] AMOUNT_FULL = 17'h10000;

  // alpha in the low byte, blue in the high byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } argb_t;

  // shadow copy of the registers, channel order red, green, blue
  logic [7:0]  dark_lvl  [3];
  logic [7:0]  light_lvl [3];
  logic [16:0] amount;

  // predicted output pixels, oldest first
  argb_t tinted_px_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [7:0] unpremultiply(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] q;
    if (a == 8'd255) return c;
    q = (16'(c) * 16'd255) / 16'(a);
    return (q > 16'd255) ? 8'd255 : q[7:0];
  endfunction

  // point on the dark-to-light line, rounded to nearest
  function automatic logic [7:0] tint_level(input logic [7:0] dark, input logic [7:0] light,
                                            input logic [7:0] luma);
    logic [16:0] num;
    num = 17'(dark) * (17'd255 - 17'(luma)) + 17'(light) * 17'(luma);
    return 8'((num + 17'd127) / 17'd255);
  endfunction

  // Q0.16 blend toward the tint, then premultiply by alpha
  function automatic logic [7:0] blend_premultiply(input logic [7:0] u, input logic [7:0] t,
                                                   input logic [16:0] amt,
                                                   input logic [7:0] a);
    logic [24:0] mix;
    logic [7:0]  level;
    logic [15:0] scaled;
    mix    = 25'(u) * 25'(AMOUNT_FULL - amt) + 25'(t) * 25'(amt) + 25'd32768;
    level  = mix[23:16];
    scaled = 16'(level) * 16'(a) + 16'd127;
    return 8'(scaled / 16'd255);
  endfunction

  function automatic argb_t tint_pixel(input argb_t px);
    argb_t       res;
    logic [16:0] amt;
    logic [7:0]  src   [3];
    logic [7:0]  un    [3];
    logic [7:0]  mixed [3];
    logic [17:0] luma_sum;
    logic [7:0]  luma;
    res = px;
    amt = (amount > AMOUNT_FULL) ? AMOUNT_FULL : amount;
    // transparent pixel or zero amount: pass through
    if (px.alpha == 8'd0 || amt == 17'd0) return res;
    src[0] = px.red;
    src[1] = px.green;
    src[2] = px.blue;
    for (int i = 0; i < 3; i++) un[i] = unpremultiply(src[i], px.alpha);
    luma_sum = 18'd299 * un[0] + 18'd587 * un[1] + 18'd114 * un[2];
    luma     = 8'(luma_sum / 18'd1000);
    for (int i = 0; i < 3; i++)
      mixed[i] = blend_premultiply(un[i], tint_level(dark_lvl[i], light_lvl[i], luma),
                                   amt, px.alpha);
    res.red   = mixed[0];
    res.green = mixed[1];
    res.blue  = mixed[2];
    return res;
  endfunction

  // watch register writes and both streams
  always @(posedge clk) begin : watch_channels
    argb_t want;
    argb_t seen;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        dark_lvl[i]  = 8'd0;
        light_lvl[i] = 8'd255;
      end
      amount = 17'd0;
      tinted_px_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (dtb_reg_e'(paddr[4:2]))
          REG_DARK_RED:     dark_lvl[0]  = pwdata[7:0];
          REG_DARK_GREEN:   dark_lvl[1]  = pwdata[7:0];
          REG_DARK_BLUE:    dark_lvl[2]  = pwdata[7:0];
          REG_LIGHT_RED:    light_lvl[0] = pwdata[7:0];
          REG_LIGHT_GREEN:  light_lvl[1] = pwdata[7:0];
          REG_LIGHT_BLUE:   light_lvl[2] = pwdata[7:0];
          REG_BLEND_AMOUNT: amount       = pwdata[16:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        tinted_px_q.push_back(tint_pixel(argb_t'(s_tdata)));
      if (m_tvalid && m_tready) begin
        seen = argb_t'(m_tdata);
        if (tinted_px_q.size() == 0) begin
          report_mismatch("unexpected output pixel, alpha", seen.alpha, 0);
        end else begin
          want = tinted_px_q.pop_front();
          if (seen.alpha !== want.alpha) report_mismatch("res_alpha", seen.alpha, want.alpha);
          if (seen.red !== want.red)     report_mismatch("res_red", seen.red, want.red);
          if (seen.green !== want.green) report_mismatch("res_green", seen.green, want.green);
          if (seen.blue !== want.blue)   report_mismatch("res_blue", seen.blue, want.blue);
        end
      end
      outstanding <= tinted_px_q.size();
    end
  end

endmodule

FILE: sim/tb_duotone_tint_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_duotone_tint_blend_unit: testbench of the duotone tint blend unit
// Directed pixels at the field extremes and special cases, then random
// pixels under random tint settings, with random gaps and backpressure.
// Prediction and checking live in tint_checker.
// ----------------------------------------------------------------------------

module tb_duotone_tint_blend_unit;
  import dtb_pkg::*;

  localparam logic [16:0] FULL_AMOUNT = 17'h10000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        steady;   // no idling on either side while set
  int unsigned outstanding;
  int unsigned fail_count;

  duotone_tint_blend_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tint_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("duotone_tint_blend_unit: mismatch");
    $finish;
  end

  // receiver backpressure
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || steady) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(99) >= 28);
    end
  end

  function automatic logic [31:0] make_pixel(input logic [7:0] a, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
    return {b, g, r, a};
  endfunction

  // mostly well-formed premultiplied pixels, some with colour above alpha
  function automatic logic [31:0] random_pixel();
    logic [7:0] a;
    logic [7:0] ch [3];
    case ($urandom_range(9))
      0:       a = 8'd0;
      1, 2:    a = 8'd255;
      3:       a = 8'($urandom_range(8, 1));
      default: a = 8'($urandom_range(254, 1));
    endcase
    for (int i = 0; i < 3; i++)
      ch[i] = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(a));
    return make_pixel(a, ch[0], ch[1], ch[2]);
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // APB write: setup phase, access phase, then idle
  task automatic write_register(input dtb_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // one input transfer, with random gaps ahead of it
  task automatic send_pixel(input logic [31:0] px);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending until every predicted pixel has come out
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic program_setting(input logic [7:0] dr, input logic [7:0] dg,
                                 input logic [7:0] db, input logic [7:0] lr,
                                 input logic [7:0] lg, input logic [7:0] lb,
                                 input logic [16:0] amt);
    write_register(REG_DARK_RED, {24'd0, dr});
    write_register(REG_DARK_GREEN, {24'd0, dg});
    write_register(REG_DARK_BLUE, {24'd0, db});
    write_register(REG_LIGHT_RED, {24'd0, lr});
    write_register(REG_LIGHT_GREEN, {24'd0, lg});
    write_register(REG_LIGHT_BLUE, {24'd0, lb});
    write_register(REG_BLEND_AMOUNT, {15'd0, amt});
  endtask

  task automatic program_random_setting();
    logic [7:0]  dark  [3];
    logic [7:0]  light [3];
    logic [16:0] amt;
    for (int i = 0; i < 3; i++) begin
      dark[i]  = random_level();
      light[i] = random_level();
    end
    // solid fill now and then
    if ($urandom_range(4) == 0) light = dark;
    case ($urandom_range(7))
      0:       amt = 17'd0;
      1:       amt = FULL_AMOUNT;
      2:       amt = 17'd1;
      3:       amt = 17'($urandom_range(131071, 65537));
      4:       amt = 17'd65535;
      default: amt = 17'($urandom_range(65536));
    endcase
    program_setting(dark[0], dark[1], dark[2], light[0], light[1], light[2], amt);
  endtask

  // stimulus and verdict
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    steady   <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero amount, pixels pass through
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(8'd128, 8'd200, 8'd10, 8'd77));
    wait_for_results();

    // half blend toward a colored ramp
    program_setting(8'd10, 8'd20, 8'd30, 8'd240, 8'd200, 8'd100, 17'h08000);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd128, 8'd7));     // transparent
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(8'd1, 8'd1, 8'd0, 8'd255));       // colour above alpha
    send_pixel(make_pixel(8'd100, 8'd200, 8'd50, 8'd100));
    send_pixel(make_pixel(8'd254, 8'd254, 8'd0, 8'd127));
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 8'd128));
    send_pixel(make_pixel(8'd37, 8'd5, 8'd30, 8'd12));
    wait_for_results();

    // solid fill at full amount
    program_setting(8'd90, 8'd160, 8'd30, 8'd90, 8'd160, 8'd30, FULL_AMOUNT);
    send_pixel(make_pixel(8'd255, 8'd10, 8'd200, 8'd40));
    send_pixel(make_pixel(8'd77, 8'd77, 8'd0, 8'd33));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    wait_for_results();

    // amount above one, inverted ramp
    program_setting(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 17'h1FFFF);
    send_pixel(make_pixel(8'd200, 8'd100, 8'd150, 8'd50));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd128, 8'd255));
    send_pixel(make_pixel(8'd3, 8'd200, 8'd2, 8'd1));
    wait_for_results();

    // smallest nonzero amount
    write_register(REG_BLEND_AMOUNT, 32'd1);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 8'd255));
    send_pixel(make_pixel(8'd9, 8'd8, 8'd9, 8'd0));
    wait_for_results();

    // random pixels under random settings; one phase without idling
    for (int ph = 0; ph < 8; ph++) begin
      program_random_setting();
      if (ph == 3) steady <= 1'b1;
      for (int n = 0; n < 215; n++) begin
        send_pixel(random_pixel());
        if ($urandom_range(149) == 0) wait_for_results();
      end
      steady <= 1'b0;
      wait_for_results();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("duotone_tint_blend_unit: match");
    end else begin
      $display("duotone_tint_blend_unit: mismatch");
    end
    $finish;
  end

endmodule
